### rtl/core/dcp_pkg.sv
package dcp_pkg;

    localparam int StackDepthDef = 64;
    localparam int StepW = 32;

    typedef enum logic [1:0] {
        KIND_ARG     = 2'd0,
        KIND_CMD     = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_STRAY    = 3'd2,
        ERR_TRUNC    = 3'd3,
        ERR_STACK    = 3'd4
    } err_t;

    localparam logic [7:0] OP_PUSH      = 8'd141;
    localparam logic [7:0] OP_POP       = 8'd142;
    localparam logic [7:0] OP_W0        = 8'd147;
    localparam logic [7:0] OP_X0        = 8'd152;
    localparam logic [7:0] OP_Y0        = 8'd161;
    localparam logic [7:0] OP_Z0        = 8'd166;
    localparam logic [7:0] OP_POST_POST = 8'd249;
    localparam logic [7:0] PAD_BYTE     = 8'd223;

    // argument size in bytes and whether it is sign extended
    typedef struct packed {
        logic       sgn;
        logic [2:0] size;
    } spec_t;

    function automatic spec_t grp_first(input logic [1:0] k);
        spec_t s;
        s.sgn  = (k == 2'd3);
        s.size = 3'(k) + 3'd1;
        return s;
    endfunction

    function automatic logic [3:0] nargs_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'd128 && c <= 8'd170) begin
            n = 4'd1;
            if (c == 8'd132 || c == 8'd137) n = 4'd2;
            if (c == 8'd138 || c == 8'd140 || c == OP_PUSH || c == OP_POP ||
                c == OP_W0 || c == OP_X0 || c == OP_Y0 || c == OP_Z0) n = 4'd0;
            if (c == 8'd139) n = 4'd11;
        end
        else if (c >= 8'd235 && c <= 8'd242) n = 4'd1;
        else if (c >= 8'd243 && c <= 8'd246) n = 4'd6;
        else if (c == 8'd247) n = 4'd5;
        else if (c == 8'd248) n = 4'd8;
        else if (c == 8'd249) n = 4'd2;
        return n;
    endfunction

    function automatic logic [2:0] off_of(input logic [7:0] c);
        logic [2:0] o;
        o = 3'd0;
        if (c >= 8'd128 && c <= 8'd131) o = 3'(c - 8'd127);
        else if (c == 8'd132 || (c >= 8'd137 && c <= 8'd142)) o = 3'd1;
        else if (c >= 8'd133 && c <= 8'd136) o = 3'(c - 8'd132);
        else if (c >= 8'd143 && c <= 8'd146) o = 3'(c - 8'd142);
        else if (c >= 8'd148 && c <= 8'd151) o = 3'(c - 8'd147);
        else if (c >= 8'd153 && c <= 8'd156) o = 3'(c - 8'd152);
        else if (c >= 8'd157 && c <= 8'd160) o = 3'(c - 8'd156);
        else if (c >= 8'd162 && c <= 8'd165) o = 3'(c - 8'd161);
        else if (c >= 8'd167 && c <= 8'd170) o = 3'(c - 8'd166);
        else if (c >= 8'd235 && c <= 8'd246) o = 3'(2'(c - 8'd235)) + 3'd1;
        else if (c >= 8'd247 && c <= 8'd249) o = 3'd1;
        return o;
    endfunction

    function automatic spec_t spec_of(input logic [7:0] c, input logic [3:0] i);
        spec_t s;
        logic [2:0] o;
        o = off_of(c);
        s = '{sgn: 1'b0, size: 3'd1};
        if (c >= 8'd128 && c <= 8'd170) begin
            if (i != 4'd0 || c == 8'd132 || c == 8'd137 || c == 8'd139)
                s = '{sgn: 1'b1, size: 3'd4};
            else if (o != 3'd0)
                s = grp_first(2'(o - 3'd1));
        end
        else if (c >= 8'd235 && c <= 8'd242) s = grp_first(2'(c - 8'd235));
        else if (c >= 8'd243 && c <= 8'd246) begin
            if (i == 4'd0) s = grp_first(2'(c - 8'd243));
            else if (i <= 4'd3) s = '{sgn: 1'b1, size: 3'd4};
        end
        else if (c == 8'd247) begin
            if (i >= 4'd1 && i <= 4'd3) s = '{sgn: 1'b1, size: 3'd4};
        end
        else if (c == 8'd248) begin
            if (i <= 4'd5) s = '{sgn: 1'b0, size: 3'd4};
            else if (i <= 4'd7) s = '{sgn: 1'b0, size: 3'd2};
        end
        else if (c == 8'd249) begin
            if (i == 4'd0) s = '{sgn: 1'b0, size: 3'd4};
        end
        return s;
    endfunction

endpackage

### rtl/core/dvi_command_parser.sv
// Latency: a result appears in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle, push and pop included; the step stack is a
// one-port-write, one-port-read RAM, and popped steps are forwarded from its read register.
// A full output register holds in_ready low only while out_ready is low.
// Reset (async, active low) clears parser state, steps and stack pointer; stack RAM is not cleared.
module dvi_command_parser
    import dcp_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  command_code,
    output logic [2:0]  group_offset,
    output logic [3:0]  arg_number,
    output logic signed [32:0] value,
    output logic [2:0]  error_code,
    output logic        command_done
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SpFull = SPW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        MODE_OPCODE,
        MODE_ARGS,
        MODE_PAYLOAD,
        MODE_PADDING
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  code_reg, code_next;
    logic [3:0]  pos_reg, pos_next;
    logic [2:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sw_reg, sw_next, sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0] pay_reg, pay_next;
    logic [7:0]  area_reg, area_next;
    logic [2:0]  pad_reg, pad_next;
    logic        pend_reg, pend_next;

    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  cc_reg, cc_next;
    logic [2:0]  off_reg, off_next;
    logic [3:0]  an_reg, an_next;
    logic [32:0] val_reg, val_next;
    logic [2:0]  err_reg, err_next;
    logic        done_reg, done_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [127:0]  wdata, rdata;
    logic [31:0]   ew, ex, ey, ez;

    logic          take;
    logic          emit;
    spec_t         sp_cur, sp_nxt, sp_op;
    logic [31:0]   acc_sh;
    logic [2:0]    left_dec;

    dcp_ram #(.WIDTH(128), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ready = !ov_reg || out_ready;
    assign take     = in_valid && in_ready;

    // steps popped last cycle come straight from the RAM read register
    assign ew = pend_reg ? rdata[127:96] : sw_reg;
    assign ex = pend_reg ? rdata[95:64]  : sx_reg;
    assign ey = pend_reg ? rdata[63:32]  : sy_reg;
    assign ez = pend_reg ? rdata[31:0]   : sz_reg;

    assign wdata = {ew, ex, ey, ez};
    assign waddr = sp_reg[AW-1:0];
    assign raddr = AW'(sp_reg - SPW'(1));

    assign sp_cur   = spec_of(code_reg, pos_reg);
    assign sp_nxt   = spec_of(code_reg, pos_reg + 4'd1);
    assign sp_op    = spec_of(data_byte, 4'd0);
    assign acc_sh   = {acc_reg[23:0], data_byte};
    assign left_dec = (left_reg != 3'd0) ? left_reg - 3'd1 : 3'd0;

    always_comb
    begin
        mode_next = mode_reg;
        code_next = code_reg;
        pos_next  = pos_reg;
        left_next = left_reg;
        acc_next  = acc_reg;
        sw_next   = ew;
        sx_next   = ex;
        sy_next   = ey;
        sz_next   = ez;
        sp_next   = sp_reg;
        pay_next  = pay_reg;
        area_next = area_reg;
        pad_next  = pad_reg;
        pend_next = 1'b0;
        we        = 1'b0;

        emit      = 1'b0;
        kind_next = KIND_CMD;
        cc_next   = code_reg;
        off_next  = 3'd0;
        an_next   = 4'd0;
        val_next  = 33'd0;
        err_next  = ERR_NONE;
        done_next = 1'b1;

        if (take)
        begin
            if (end_of_stream)
            begin
                if (mode_reg == MODE_ARGS || mode_reg == MODE_PAYLOAD)
                begin
                    emit      = 1'b1;
                    kind_next = KIND_ERROR;
                    err_next  = ERR_TRUNC;
                end
                else if (mode_reg == MODE_PADDING && pad_reg < 3'd4)
                begin
                    emit      = 1'b1;
                    kind_next = KIND_ERROR;
                    err_next  = ERR_SHORT;
                end
                mode_next = MODE_OPCODE;
                pos_next  = 4'd0;
                left_next = 3'd0;
                acc_next  = 32'd0;
                pay_next  = 32'd0;
                pad_next  = 3'd0;
            end
            else
            begin
                case (mode_reg)
                    MODE_ARGS:
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_ARG;
                        off_next  = off_of(code_reg);
                        an_next   = pos_reg;
                        done_next = 1'b0;
                        acc_next  = acc_sh;
                        left_next = left_dec;
                        if (left_dec != 3'd0)
                        begin
                            emit = 1'b0;
                        end
                        else
                        begin
                            val_next = sp_cur.sgn ? {acc_sh[31], acc_sh} : {1'b0, acc_sh};
                            if (code_reg >= 8'd148 && code_reg <= 8'd151) sw_next = acc_sh;
                            else if (code_reg >= 8'd153 && code_reg <= 8'd156) sx_next = acc_sh;
                            else if (code_reg >= 8'd162 && code_reg <= 8'd165) sy_next = acc_sh;
                            else if (code_reg >= 8'd167 && code_reg <= 8'd170) sz_next = acc_sh;
                            else if (code_reg >= 8'd239 && code_reg <= 8'd242) pay_next = acc_sh;
                            else if (code_reg >= 8'd243 && code_reg <= 8'd246 &&
                                     pos_reg == 4'd4)
                                area_next = acc_sh[7:0];
                            else if (code_reg >= 8'd243 && code_reg <= 8'd246 &&
                                     pos_reg == 4'd5)
                                pay_next = 32'({1'b0, area_reg} + {1'b0, acc_sh[7:0]});
                            else if (code_reg == 8'd247 && pos_reg == 4'd4)
                                pay_next = acc_sh;

                            if (pos_reg + 4'd1 >= nargs_of(code_reg))
                            begin
                                if (pay_next != 32'd0)
                                begin
                                    mode_next = MODE_PAYLOAD;
                                end
                                else if (code_reg == OP_POST_POST)
                                begin
                                    mode_next = MODE_PADDING;
                                    pad_next  = 3'd0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    mode_next = MODE_OPCODE;
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                pos_next  = pos_reg + 4'd1;
                                acc_next  = 32'd0;
                                left_next = sp_nxt.size;
                            end
                        end
                    end
                    MODE_PAYLOAD:
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_PAYLOAD;
                        off_next  = off_of(code_reg);
                        val_next  = {25'd0, data_byte};
                        if (pay_reg > 32'd0) pay_next = pay_reg - 32'd1;
                        done_next = (pay_next == 32'd0);
                        if (pay_next == 32'd0) mode_next = MODE_OPCODE;
                    end
                    MODE_PADDING:
                    begin
                        if (data_byte == PAD_BYTE)
                        begin
                            if (pad_reg < 3'd4) pad_next = pad_reg + 3'd1;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            kind_next = KIND_ERROR;
                            err_next  = (pad_reg < 3'd4) ? ERR_SHORT : ERR_STRAY;
                            mode_next = MODE_OPCODE;
                            pos_next  = 4'd0;
                            left_next = 3'd0;
                            acc_next  = 32'd0;
                            pay_next  = 32'd0;
                            pad_next  = 3'd0;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_OPCODE;
                        cc_next   = data_byte;
                        if (data_byte <= 8'd127)
                        begin
                            emit     = 1'b1;
                            val_next = {25'd0, data_byte};
                        end
                        else if (data_byte >= 8'd171 && data_byte <= 8'd234)
                        begin
                            emit     = 1'b1;
                            val_next = {25'd0, data_byte - 8'd171};
                        end
                        else if (data_byte >= 8'd250)
                        begin
                            emit = 1'b0;
                        end
                        else if (nargs_of(data_byte) == 4'd0)
                        begin
                            emit     = 1'b1;
                            off_next = off_of(data_byte);
                            if (data_byte == OP_PUSH)
                            begin
                                if (sp_reg >= SpFull)
                                begin
                                    kind_next = KIND_ERROR;
                                    err_next  = ERR_STACK;
                                    off_next  = 3'd0;
                                end
                                else
                                begin
                                    we      = 1'b1;
                                    sp_next = sp_reg + SPW'(1);
                                end
                            end
                            else if (data_byte == OP_POP)
                            begin
                                if (sp_reg == SPW'(0) || sp_reg > SpFull)
                                begin
                                    kind_next = KIND_ERROR;
                                    err_next  = ERR_STACK;
                                    off_next  = 3'd0;
                                end
                                else
                                begin
                                    sp_next   = sp_reg - SPW'(1);
                                    pend_next = 1'b1;
                                end
                            end
                            else if (data_byte == OP_W0) val_next = {ew[31], ew};
                            else if (data_byte == OP_X0) val_next = {ex[31], ex};
                            else if (data_byte == OP_Y0) val_next = {ey[31], ey};
                            else if (data_byte == OP_Z0) val_next = {ez[31], ez};
                        end
                        else
                        begin
                            code_next = data_byte;
                            pos_next  = 4'd0;
                            acc_next  = 32'd0;
                            pay_next  = 32'd0;
                            left_next = sp_op.size;
                            mode_next = MODE_ARGS;
                        end
                    end
                endcase
            end
        end

        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OPCODE;
            code_reg <= 8'd0;
            pos_reg  <= 4'd0;
            left_reg <= 3'd0;
            acc_reg  <= 32'd0;
            sw_reg   <= 32'd0;
            sx_reg   <= 32'd0;
            sy_reg   <= 32'd0;
            sz_reg   <= 32'd0;
            sp_reg   <= '0;
            pay_reg  <= 32'd0;
            area_reg <= 8'd0;
            pad_reg  <= 3'd0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            code_reg <= code_next;
            pos_reg  <= pos_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
            sw_reg   <= sw_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            sz_reg   <= sz_next;
            sp_reg   <= sp_next;
            pay_reg  <= pay_next;
            area_reg <= area_next;
            pad_reg  <= pad_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            cc_reg   <= cc_next;
            off_reg  <= off_next;
            an_reg   <= an_next;
            val_reg  <= val_next;
            err_reg  <= err_next;
            done_reg <= done_next;
        end
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign command_code = cc_reg;
    assign group_offset = off_reg;
    assign arg_number   = an_reg;
    assign value        = val_reg;
    assign error_code   = err_reg;
    assign command_done = done_reg;

endmodule

### rtl/core/dcp_ram.sv
module dcp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/dcp_checker.sv
module dcp_checker
    import dcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [3:0]  arg_number,
    input  logic signed [32:0] value,
    input  logic [2:0]  error_code,
    input  logic        command_done
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value))
        else $error("request dropped or changed while stalled");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |->
            command_done && error_code != ERR_NONE && value == 33'sd0 && arg_number == 4'd0)
        else $error("malformed error request");

    a_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error request");

    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |-> value[32:8] == 25'd0 && arg_number == 4'd0)
        else $error("payload byte out of range");

endmodule

bind dvi_command_parser dcp_checker u_dcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .arg_number   (arg_number),
    .value        (value),
    .error_code   (error_code),
    .command_done (command_done)
);

### tb/sv/dvi_command_parser_tb.sv
module dvi_command_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dcp_pkg::*;

    localparam int DEPTH = 64;
    localparam int WDOG_LIMIT = 5000;
    localparam int QUIET_TAIL = 60;
    localparam int N_RANDOM = 600;

    typedef enum int {M_OPCODE, M_ARGS, M_PAYLOAD, M_PADDING} pmode_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  code;
        logic [2:0]  off;
        logic [3:0]  argn;
        logic [32:0] val;
        err_t        err;
        logic        done;
    } res_t;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         lit;
        res_t       r;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  command_code;
    logic [2:0]  group_offset;
    logic [3:0]  arg_number;
    logic signed [32:0] value;
    logic [2:0]  error_code;
    logic        command_done;

    dvi_command_parser dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // opcode tables for 128..170 and the fixed argument lists
    int lo_nargs[43] = '{1,1,1,1,2,1,1,1,1,2,0,11,0,0,0,1,1,1,1,0,1,1,1,1,0,
                         1,1,1,1,1,1,1,1,0,1,1,1,1,0,1,1,1,1};
    int lo_spec[43]  = '{1,2,3,-4,-4,1,2,3,-4,-4,0,-4,0,0,0,1,2,3,-4,0,1,2,3,-4,0,
                         1,2,3,-4,1,2,3,-4,0,1,2,3,-4,0,1,2,3,-4};
    int lo_off[43]   = '{1,2,3,4,1,1,2,3,4,1,1,1,1,1,1,1,2,3,4,0,1,2,3,4,0,
                         1,2,3,4,1,2,3,4,0,1,2,3,4,0,1,2,3,4};
    int fdef_rest[5] = '{-4,-4,-4,1,1};
    int pre_list[5]  = '{1,-4,-4,-4,1};
    int post_list[8] = '{4,4,4,4,4,4,2,2};
    int pp_list[2]   = '{4,1};
    int grp_list[4]  = '{1,2,3,-4};

    // parser shadow state
    pmode_t      p_mode;
    logic [7:0]  p_code;
    int          p_pos, p_left, p_pad, p_sp;
    logic [31:0] p_acc, p_plen, p_w, p_x, p_y, p_z;
    logic [7:0]  p_area;
    logic [31:0] p_stack[DEPTH][4];

    stim_t stim_q[$];
    res_t  result_q[$];
    int    errors = 0;
    bit    quiet = 1'b0;
    int    idle_cycles = 0;

    function automatic int arg_count(logic [7:0] c);
        if (c >= 128 && c <= 170) return lo_nargs[c - 128];
        if (c >= 235 && c <= 242) return 1;
        if (c >= 243 && c <= 246) return 6;
        if (c == 247) return 5;
        if (c == 248) return 8;
        if (c == 249) return 2;
        return 0;
    endfunction

    // size in bytes, negative when sign extended
    function automatic int arg_spec(logic [7:0] c, int i);
        int s;
        s = 1;
        if (c >= 128 && c <= 170) s = (i == 0) ? lo_spec[c - 128] : -4;
        else if (c >= 235 && c <= 242) s = grp_list[(c - 235) & 3];
        else if (c >= 243 && c <= 246) s = (i == 0) ? grp_list[c - 243] :
                                           (i <= 5 ? fdef_rest[i - 1] : 1);
        else if (c == 247 && i < 5) s = pre_list[i];
        else if (c == 248 && i < 8) s = post_list[i];
        else if (c == 249 && i < 2) s = pp_list[i];
        return (s == 0) ? 1 : s;
    endfunction

    function automatic int group_pos(logic [7:0] c);
        if (c >= 128 && c <= 170) return lo_off[c - 128];
        if (c >= 235 && c <= 246) return ((c - 235) & 3) + 1;
        if (c >= 247 && c <= 249) return 1;
        return 0;
    endfunction

    function automatic res_t mk(kind_t k, logic [7:0] c, int o, int a, logic [32:0] v,
                                err_t e, logic d);
        res_t r;
        r.kind = k; r.code = c; r.off = 3'(o); r.argn = 4'(a);
        r.val = v; r.err = e; r.done = d;
        return r;
    endfunction

    task automatic clear_parse();
        p_mode = M_OPCODE; p_pos = 0; p_left = 0; p_acc = 0; p_plen = 0; p_pad = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eos,
                              output bit has, output res_t r);
        int s, sz;
        logic [32:0] v;
        has = 1'b0;
        if (eos)
        begin
            if (p_mode == M_ARGS || p_mode == M_PAYLOAD)
            begin
                has = 1'b1; r = mk(KIND_ERROR, p_code, 0, 0, 0, ERR_TRUNC, 1'b1);
            end
            else if (p_mode == M_PADDING && p_pad < 4)
            begin
                has = 1'b1; r = mk(KIND_ERROR, p_code, 0, 0, 0, ERR_SHORT, 1'b1);
            end
            clear_parse();
            return;
        end
        case (p_mode)
            M_ARGS:
            begin
                s = arg_spec(p_code, p_pos);
                sz = (s < 0) ? -s : s;
                p_acc = (p_acc << 8) | b;
                if (p_left > 0) p_left--;
                if (p_left != 0) return;
                v = {1'b0, p_acc};
                if (s < 0)
                    for (int k = sz * 8; k < 33; k++) v[k] = p_acc[sz * 8 - 1];
                if (p_code >= 148 && p_code <= 151) p_w = p_acc;
                else if (p_code >= 153 && p_code <= 156) p_x = p_acc;
                else if (p_code >= 162 && p_code <= 165) p_y = p_acc;
                else if (p_code >= 167 && p_code <= 170) p_z = p_acc;
                else if (p_code >= 239 && p_code <= 242) p_plen = p_acc;
                else if (p_code >= 243 && p_code <= 246 && p_pos == 4) p_area = p_acc[7:0];
                else if (p_code >= 243 && p_code <= 246 && p_pos == 5)
                    p_plen = 32'(p_area) + 32'(p_acc[7:0]);
                else if (p_code == 247 && p_pos == 4) p_plen = p_acc;
                has = 1'b1;
                r = mk(KIND_ARG, p_code, group_pos(p_code), p_pos, v, ERR_NONE, 1'b0);
                if (p_pos + 1 >= arg_count(p_code))
                begin
                    if (p_plen != 0) p_mode = M_PAYLOAD;
                    else if (p_code == OP_POST_POST)
                    begin
                        p_mode = M_PADDING; p_pad = 0; r.done = 1'b1;
                    end
                    else
                    begin
                        p_mode = M_OPCODE; r.done = 1'b1;
                    end
                end
                else
                begin
                    p_pos++;
                    p_acc = 0;
                    s = arg_spec(p_code, p_pos);
                    p_left = (s < 0) ? -s : s;
                end
            end
            M_PAYLOAD:
            begin
                if (p_plen > 0) p_plen--;
                has = 1'b1;
                r = mk(KIND_PAYLOAD, p_code, group_pos(p_code), 0, {25'd0, b}, ERR_NONE,
                       p_plen == 0);
                if (p_plen == 0) p_mode = M_OPCODE;
            end
            M_PADDING:
            begin
                if (b == PAD_BYTE)
                begin
                    if (p_pad < 4) p_pad++;
                    return;
                end
                has = 1'b1;
                r = mk(KIND_ERROR, p_code, 0, 0, 0, (p_pad < 4) ? ERR_SHORT : ERR_STRAY, 1'b1);
                clear_parse();
            end
            default:
            begin
                if (b <= 127)
                begin
                    has = 1'b1; r = mk(KIND_CMD, b, 0, 0, {25'd0, b}, ERR_NONE, 1'b1);
                end
                else if (b >= 171 && b <= 234)
                begin
                    has = 1'b1; r = mk(KIND_CMD, b, 0, 0, 33'(b - 171), ERR_NONE, 1'b1);
                end
                else if (b >= 250)
                    return;
                else if (arg_count(b) == 0)
                begin
                    has = 1'b1;
                    r = mk(KIND_CMD, b, group_pos(b), 0, 0, ERR_NONE, 1'b1);
                    if (b == OP_PUSH)
                    begin
                        if (p_sp >= DEPTH) r = mk(KIND_ERROR, b, 0, 0, 0, ERR_STACK, 1'b1);
                        else
                        begin
                            p_stack[p_sp] = '{p_w, p_x, p_y, p_z};
                            p_sp++;
                        end
                    end
                    else if (b == OP_POP)
                    begin
                        if (p_sp == 0) r = mk(KIND_ERROR, b, 0, 0, 0, ERR_STACK, 1'b1);
                        else
                        begin
                            p_sp--;
                            p_w = p_stack[p_sp][0]; p_x = p_stack[p_sp][1];
                            p_y = p_stack[p_sp][2]; p_z = p_stack[p_sp][3];
                        end
                    end
                    else if (b == OP_W0) r.val = {p_w[31], p_w};
                    else if (b == OP_X0) r.val = {p_x[31], p_x};
                    else if (b == OP_Y0) r.val = {p_y[31], p_y};
                    else if (b == OP_Z0) r.val = {p_z[31], p_z};
                end
                else
                begin
                    p_code = b; p_pos = 0; p_acc = 0; p_plen = 0;
                    s = arg_spec(b, 0);
                    p_left = (s < 0) ? -s : s;
                    p_mode = M_ARGS;
                end
            end
        endcase
    endtask

    task automatic add(logic [7:0] b, logic eos = 1'b0);
        stim_t t;
        t.b = b; t.eos = eos; t.lit = 1'b0;
        stim_q.push_back(t);
    endtask

    task automatic add_lit(logic [7:0] b, logic eos, res_t r);
        stim_t t;
        t.b = b; t.eos = eos; t.lit = 1'b1; t.r = r;
        stim_q.push_back(t);
    endtask

    task automatic put_be(ref stim_t cmd[$], input logic [31:0] val, input int sz);
        stim_t t;
        t.eos = 1'b0; t.lit = 1'b0;
        for (int k = sz - 1; k >= 0; k--)
        begin
            t.b = val[k * 8 +: 8];
            cmd.push_back(t);
        end
    endtask

    // one command with random content and short strings; sometimes cut short
    task automatic gen_command();
        stim_t cmd[$];
        stim_t t;
        logic [7:0] c;
        int n, s, sz, slen, area, sel, cut;
        sel = $urandom_range(0, 19);
        t.lit = 1'b0; t.eos = 1'b0;
        if (sel < 3)
        begin
            t.b = 8'($urandom);
            cmd.push_back(t);
        end
        else if (sel == 3)
        begin
            t.b = 8'($urandom); t.eos = 1'b1;
            cmd.push_back(t);
        end
        else
        begin
            c = 8'($urandom_range(128, 249));
            t.b = c;
            cmd.push_back(t);
            n = arg_count(c);
            slen = 0; area = 0;
            for (int i = 0; i < n; i++)
            begin
                s = arg_spec(c, i);
                sz = (s < 0) ? -s : s;
                if ((c >= 239 && c <= 242 && i == 0) || (c == 247 && i == 4))
                begin
                    slen = $urandom_range(0, 5); put_be(cmd, slen, sz);
                end
                else if (c >= 243 && c <= 246 && i == 4)
                begin
                    area = $urandom_range(0, 3); put_be(cmd, area, sz);
                end
                else if (c >= 243 && c <= 246 && i == 5)
                begin
                    slen = $urandom_range(0, 3); put_be(cmd, slen, sz);
                    slen += area;
                end
                else
                    put_be(cmd, $urandom, sz);
            end
            for (int i = 0; i < slen; i++) put_be(cmd, $urandom, 1);
            if (c == OP_POST_POST)
            begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) put_be(cmd, PAD_BYTE, 1);
                t.b = 8'($urandom); t.eos = $urandom_range(0, 1);
                cmd.push_back(t);
            end
            else if (cmd.size() > 1 && $urandom_range(0, 19) == 0)
            begin
                cut = $urandom_range(1, cmd.size() - 1);
                while (cmd.size() > cut) void'(cmd.pop_back());
                t.b = 8'($urandom); t.eos = 1'b1;
                cmd.push_back(t);
            end
        end
        foreach (cmd[i]) stim_q.push_back(cmd[i]);
    endtask

    task automatic check_field(string name, logic [32:0] e, logic [32:0] a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $error("result with no request pending: kind %0d code %0d", kind, command_code);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                check_field("kind", e.kind, kind);
                check_field("command_code", e.code, command_code);
                check_field("group_offset", e.off, group_offset);
                check_field("arg_number", e.argn, arg_number);
                check_field("value", e.val, value);
                check_field("error_code", e.err, error_code);
                check_field("command_done", e.done, command_done);
            end
        end
    end

    // receiver stalls
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("dvi_command_parser_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        bit   has;
        res_t r;
        int   pause_at, storm_at;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        end_of_stream = 1'b0;
        out_ready = 1'b0;
        p_sp = 0; p_code = 0; p_area = 0;
        p_w = 0; p_x = 0; p_y = 0; p_z = 0;
        clear_parse();

        // directed rows
        add_lit(8'd0, 1'b0, mk(KIND_CMD, 8'd0, 0, 0, 33'd0, ERR_NONE, 1'b1));
        add_lit(8'd127, 1'b0, mk(KIND_CMD, 8'd127, 0, 0, 33'd127, ERR_NONE, 1'b1));
        add_lit(8'd171, 1'b0, mk(KIND_CMD, 8'd171, 0, 0, 33'd0, ERR_NONE, 1'b1));
        add_lit(8'd234, 1'b0, mk(KIND_CMD, 8'd234, 0, 0, 33'd63, ERR_NONE, 1'b1));
        add_lit(OP_POP, 1'b0, mk(KIND_ERROR, OP_POP, 0, 0, 33'd0, ERR_STACK, 1'b1));
        add(8'd250);
        add(8'd255);
        add(8'd0, 1'b1);                 // end of stream while idle
        add(8'd151); add(8'h80); add(8'h00); add(8'h00); add(8'h00);   // w4 most negative
        add(OP_W0);
        add(OP_PUSH);
        add(8'd167); add(8'hFF);         // z1
        add(OP_POP);
        add(OP_Z0);
        // xxx4 with a negative length counts as huge, then gets truncated
        add(8'd242); add(8'hFF); add(8'hFF); add(8'hFF); add(8'hFF);
        add(8'h41);
        add_lit(8'd0, 1'b1, mk(KIND_ERROR, 8'd242, 0, 0, 33'd0, ERR_TRUNC, 1'b1));
        add(8'd239); add(8'd0);          // zero length xxx1
        add(OP_POST_POST); add(8'hFF); add(8'hFF); add(8'hFF); add(8'hFF); add(8'hFF);
        repeat (5) add(PAD_BYTE);
        add_lit(8'd0, 1'b0, mk(KIND_ERROR, OP_POST_POST, 0, 0, 33'd0, ERR_STRAY, 1'b1));

        storm_at = stim_q.size() + 200;
        while (stim_q.size() < storm_at) gen_command();
        // overflow and underflow of the step stack
        add(8'd163); add(8'h12); add(8'h34); add(8'h56);
        repeat (DEPTH + 1) add(OP_PUSH);
        repeat (DEPTH + 2) add(OP_POP);
        pause_at = stim_q.size() + 50;
        while (stim_q.size() < N_RANDOM) gen_command();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_q[i])
        begin
            quiet = (i >= stim_q.size() - QUIET_TAIL);
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (result_q.size() != 0) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= stim_q[i].b;
            end_of_stream <= stim_q[i].eos;
            do @(posedge clk); while (!in_ready);
            parse_byte(stim_q[i].b, stim_q[i].eos, has, r);
            if (has) result_q.push_back(stim_q[i].lit ? stim_q[i].r : r);
        end
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("dvi_command_parser_tb: PASS");
        else
            $display("dvi_command_parser_tb: FAIL");
        $finish;
    end
endmodule
